>>> rtl/pps_pkg.sv
// Package for the power path sequencer: state codes, charger status codes
// and the state record passed between the top level and the evaluation logic.
// Depends on nothing.
`default_nettype none

package pps_pkg;

    typedef enum logic [2:0] {
        ST_ENTRY     = 3'd0,
        ST_USB       = 3'd1,
        ST_HIGH      = 3'd2,
        ST_CHARGED   = 3'd3,
        ST_DISCHARGE = 3'd4,
        ST_OFF       = 3'd5
    } power_state_t;

    typedef enum logic [1:0] {
        CHG_PRECHARGE = 2'd0,
        CHG_FAST      = 2'd1,
        CHG_DONE      = 2'd2,
        CHG_SUSPENDED = 2'd3
    } charger_status_t;

    localparam int RAIL_3V_BIT = 0;
    localparam int RAIL_5V_BIT = 1;
    localparam int RAIL_6V_BIT = 2;

    localparam logic [2:0] RAILS_3V_ONLY = 3'b001;
    localparam logic [2:0] RAILS_ALL     = 3'b111;
    localparam logic [2:0] RAILS_NONE    = 3'b000;

    // Architectural state that one evaluation reads and writes.
    typedef struct packed {
        power_state_t state;
        logic [2:0]   rails;
        logic         charger_mode;
        logic         on_flag;
    } pps_ctx_t;

    // Conditions sampled on the current tick.
    typedef struct packed {
        logic            usb_conn;
        logic            button;
        logic            battery_ok;
        charger_status_t charger;
    } pps_cond_t;

endpackage

`default_nettype wire

>>> rtl/pps_eval.sv
// Next-state logic of the six-state power FSM for one evaluation.
// Purely combinational; uses types and codes from pps_pkg.
`default_nettype none

module pps_eval (
    input  var pps_pkg::pps_ctx_t  ctx_in,
    input  var pps_pkg::pps_cond_t cond,
    output pps_pkg::pps_ctx_t      ctx_out,
    output logic                   shutdown
);
    import pps_pkg::*;

    logic pc;
    logic btn;
    logic ok;
    logic on;

    assign pc  = cond.usb_conn;
    assign btn = cond.button;
    assign ok  = cond.battery_ok;
    assign on  = ctx_in.on_flag;

    always_comb begin
        logic go_off;
        go_off   = 1'b0;
        ctx_out  = ctx_in;
        case (ctx_in.state)
            ST_ENTRY: begin
                if (pc) begin
                    ctx_out.rails        = RAILS_3V_ONLY;
                    ctx_out.charger_mode = 1'b0;
                    ctx_out.state        = ST_USB;
                end else if (btn && ok) begin
                    ctx_out.rails   = RAILS_ALL;
                    ctx_out.on_flag = 1'b1;
                    ctx_out.state   = ST_DISCHARGE;
                end else if (cond.charger != CHG_SUSPENDED) begin
                    ctx_out.rails[RAIL_3V_BIT] = 1'b1;
                    ctx_out.charger_mode       = 1'b1;
                    ctx_out.state              = ST_HIGH;
                end else if (!ok) begin
                    go_off = 1'b1;
                end
            end
            ST_USB: begin
                if (!pc && !on) begin
                    go_off = 1'b1;
                end else if (btn && ok && !on) begin
                    ctx_out.rails   = RAILS_ALL;
                    ctx_out.on_flag = 1'b1;
                    ctx_out.state   = ST_DISCHARGE;
                end else if (!ok) begin
                    go_off = 1'b1;
                end else if (cond.charger == CHG_DONE && on) begin
                    ctx_out.state = ST_CHARGED;
                end
            end
            ST_HIGH: begin
                if (btn && ok && !on) begin
                    ctx_out.rails   = RAILS_ALL;
                    ctx_out.on_flag = 1'b1;
                    ctx_out.state   = ST_DISCHARGE;
                end else if (btn && ok && on) begin
                    go_off = 1'b1;
                end else if (cond.charger == CHG_SUSPENDED && ok && on) begin
                    ctx_out.state = ST_DISCHARGE;
                end else if (!ok) begin
                    go_off = 1'b1;
                end else if (cond.charger == CHG_DONE && on) begin
                    ctx_out.state = ST_CHARGED;
                end
            end
            ST_CHARGED: begin
                if (!pc && cond.charger != CHG_DONE && ok && on) begin
                    ctx_out.state = ST_DISCHARGE;
                end else if (pc) begin
                    ctx_out.state = ST_USB;
                end else if (cond.charger != CHG_SUSPENDED) begin
                    ctx_out.state = ST_HIGH;
                end else if (btn && on) begin
                    go_off = 1'b1;
                end else if (!ok) begin
                    go_off = 1'b1;
                end
            end
            ST_DISCHARGE: begin
                if (btn && ok && !on) begin
                    ctx_out.state        = ST_USB;
                    ctx_out.charger_mode = 1'b0;
                end else if (!pc && cond.charger != CHG_SUSPENDED) begin
                    ctx_out.state        = ST_HIGH;
                    ctx_out.charger_mode = 1'b1;
                end else if (btn && on) begin
                    go_off = 1'b1;
                end else if (!ok) begin
                    go_off = 1'b1;
                end
            end
            default: begin
                // The off state and the unused codes hold everything.
                ctx_out = ctx_in;
            end
        endcase
        // The turn-off sequence drops the rails but leaves device-on alone.
        if (go_off) begin
            ctx_out.state = ST_OFF;
            ctx_out.rails = RAILS_NONE;
        end
        shutdown = go_off;
    end

endmodule

`default_nettype wire

>>> rtl/power_path_sequencer.sv
// Top level of the power path sequencer: stream handshake, held FSM state
// and the result register. Depends on pps_pkg and pps_eval.
`default_nettype none

//  Channel   Direction  Bits  Contents
//  s_*       in         8     one update tick (charger pins, USB, battery, button)
//  m_*       out        16    state, rail enables, charger mode, flags
//
// Every tick accepted gives exactly one result transfer. The evaluation is a
// single pass of logic from the incoming tick and the held state into the
// result register, so one tick is accepted per clock cycle and its result
// appears in the next cycle. The input side stalls only while a result waits
// and the output side is not ready. Reset (aresetn low, synchronous) returns
// the FSM to the entry state with all rails off and drops any pending result.

module power_path_sequencer (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [0] charger_stat1, [1] charger_stat2, [2] usb_configured,
    // [3] battery_ok, [4] button_long_press, [7:5] zero
    input  wire logic [7:0]  s_tdata,

    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [2:0] power_state, [3] rail_3v_enable, [4] rail_5v_enable,
    // [5] rail_6v_enable, [6] charger_high_power, [7] device_on,
    // [8] shutdown_strobe, [9] evaluated, [15:10] zero
    output logic [15:0]      m_tdata
);
    import pps_pkg::*;

    // Held state of the sequencer.
    pps_ctx_t        ctx_reg;
    pps_ctx_t        ctx_next;
    charger_status_t last_chg_reg;
    logic            last_bat_reg;

    // Result register.
    logic        m_valid_reg;
    logic [15:0] m_data_reg;
    logic [15:0] m_data_next;

    logic        in_xfer;
    pps_cond_t   cond;
    logic        event_hit;
    pps_ctx_t    eval_ctx;
    logic        eval_shut;
    logic        shut_flag;

    // A new tick may enter whenever the result register is empty or is being
    // emptied in this same cycle.
    assign s_tready = !m_valid_reg || m_tready;
    assign in_xfer  = s_tvalid && s_tready;

    assign cond.charger    = charger_status_t'({s_tdata[0], s_tdata[1]});
    assign cond.usb_conn   = s_tdata[2];
    assign cond.battery_ok = s_tdata[3];
    assign cond.button     = s_tdata[4];

    // A press always forces an evaluation and is consumed by it, so no press
    // ever remains pending between ticks and none needs to be stored.
    assign event_hit = cond.button || cond.usb_conn ||
                       (cond.charger != last_chg_reg) ||
                       (cond.battery_ok != last_bat_reg);

    pps_eval u_eval (
        .ctx_in   (ctx_reg),
        .cond     (cond),
        .ctx_out  (eval_ctx),
        .shutdown (eval_shut)
    );

    always_comb begin
        ctx_next    = event_hit ? eval_ctx : ctx_reg;
        shut_flag   = event_hit && eval_shut;
        m_data_next = {6'b0, event_hit, shut_flag, ctx_next.on_flag,
                       ctx_next.charger_mode, ctx_next.rails[RAIL_6V_BIT],
                       ctx_next.rails[RAIL_5V_BIT], ctx_next.rails[RAIL_3V_BIT],
                       ctx_next.state};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctx_reg.state        <= ST_ENTRY;
            ctx_reg.rails        <= RAILS_NONE;
            ctx_reg.charger_mode <= 1'b0;
            ctx_reg.on_flag      <= 1'b0;
            last_chg_reg         <= CHG_SUSPENDED;
            last_bat_reg         <= 1'b1;
        end else if (in_xfer) begin
            ctx_reg      <= ctx_next;
            last_chg_reg <= cond.charger;
            last_bat_reg <= cond.battery_ok;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (in_xfer) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

`default_nettype wire
